// ===== rtl/osrq_pkg.sv =====
// package with types and constants for the ordered set rank query block
`timescale 1ns / 1ps
package osrq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned RANK_W   = 12;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_DELETE = 3'd1,
    FN_EXISTS = 3'd2,
    FN_NEXT   = 3'd3,
    FN_PREV   = 3'd4,
    FN_KTH    = 3'd5
  } osrq_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } osrq_state_e;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
    logic pick_next;
    logic pick_prev;
    logic pick_kth;
  } osrq_ctl_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    valid;
    logic                    lt;
    logic                    gt;
  } osrq_link_t;

endpackage

// ===== rtl/osrq_cell.sv =====
// one sorted cell: holds a key, compares it and shifts with its neighbors
`timescale 1ns / 1ps
module osrq_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  osrq_pkg::osrq_ctl_t                   ctl_i,
  input  logic signed [osrq_pkg::KEY_W-1:0]     op_key_i,
  input  logic                                  rank_sel_i,
  input  osrq_pkg::osrq_link_t                  left_i,
  input  osrq_pkg::osrq_link_t                  right_i,
  output osrq_pkg::osrq_link_t                  link_o,
  output logic                                  eq_o,
  output logic                                  pick_o
);

  logic signed [osrq_pkg::KEY_W-1:0] key_q, key_d;
  logic                              valid_q, valid_d;
  logic                              lt_q, eq_q, gt_q;
  logic                              lt_d, eq_d, gt_d;

  always_comb begin
    lt_d = valid_q && (key_q < op_key_i);
    eq_d = valid_q && (key_q == op_key_i);
    gt_d = valid_q && !lt_d && !eq_d;
  end

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctl_i.ins_en && !lt_q) begin
      if (left_i.lt) begin
        key_d   = op_key_i;
        valid_d = 1'b1;
      end else begin
        key_d   = left_i.key;
        valid_d = left_i.valid;
      end
    end else if (ctl_i.del_en && !lt_q) begin
      key_d   = right_i.key;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (ctl_i.cmp_en) begin
      lt_q <= lt_d;
      eq_q <= eq_d;
      gt_q <= gt_d;
    end
  end

  always_comb begin
    link_o.key   = key_q;
    link_o.valid = valid_q;
    link_o.lt    = lt_q;
    link_o.gt    = gt_q;
    eq_o         = eq_q;
    pick_o       = (ctl_i.pick_next && gt_q && !left_i.gt)
                || (ctl_i.pick_prev && lt_q && !right_i.lt)
                || (ctl_i.pick_kth && rank_sel_i && valid_q);
  end

endmodule

// ===== rtl/ordered_set_rank_query.sv =====
// top level of the ordered set with rank queries, built as a sorted cell chain
//
//  channel | signals                          | direction
//  in      | in_valid_i/in_ready_o, func_i,   | operation transfer into the block
//          | key_i, rank_i                    |
//  out     | out_valid_o/out_ready_i, found_o,| one result transfer per operation
//          | value_o, overflow_o              |
//
// an item goes through transfer, parallel compare in every cell, then execute
// the execute step shifts the chain for insert or delete and registers the result
// a new item is taken once the previous one has its result registered
// execute waits while the output register holds a result not yet taken
// reset empties the set by clearing every cell valid bit at once
`timescale 1ns / 1ps
module ordered_set_rank_query (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [osrq_pkg::FUNC_W-1:0]           func_i,
  input  logic signed [osrq_pkg::KEY_W-1:0]     key_i,
  input  logic [osrq_pkg::RANK_W-1:0]           rank_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  found_o,
  output logic signed [osrq_pkg::KEY_W-1:0]     value_o,
  output logic                                  overflow_o
);

  localparam int unsigned CAP = osrq_pkg::CAPACITY;

  osrq_pkg::osrq_state_e              state_q, state_d;
  logic [osrq_pkg::FUNC_W-1:0]        func_q;
  logic signed [osrq_pkg::KEY_W-1:0]  key_q;
  logic [osrq_pkg::RANK_W-1:0]        rank_q;
  logic                               in_fire, exec_fire;

  osrq_pkg::osrq_ctl_t                ctl;
  osrq_pkg::osrq_link_t               link [CAP+2];
  logic [CAP-1:0]                     eq_v, pick_v, valid_v;

  logic                               present, full, any_pick;
  logic signed [osrq_pkg::KEY_W-1:0]  pick_val;
  logic                               found_d, overflow_d;
  logic signed [osrq_pkg::KEY_W-1:0]  value_d;
  logic                               out_valid_q, found_q, overflow_q;
  logic signed [osrq_pkg::KEY_W-1:0]  value_q;

  // chain ends
  always_comb begin
    link[0].key       = '0;
    link[0].valid     = 1'b0;
    link[0].lt        = 1'b1;
    link[0].gt        = 1'b0;
    link[CAP+1].key   = '0;
    link[CAP+1].valid = 1'b0;
    link[CAP+1].lt    = 1'b0;
    link[CAP+1].gt    = 1'b0;
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    osrq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .op_key_i   (key_q),
      .rank_sel_i (rank_q == osrq_pkg::RANK_W'(i)),
      .left_i     (link[i]),
      .right_i    (link[i+2]),
      .link_o     (link[i+1]),
      .eq_o       (eq_v[i]),
      .pick_o     (pick_v[i])
    );
    assign valid_v[i] = link[i+1].valid;
  end

  always_comb begin
    present  = |eq_v;
    any_pick = |pick_v;
    full     = link[CAP].valid;
    pick_val = '0;
    for (int i = 0; i < CAP; i++) begin
      pick_val = pick_val | (link[i+1].key & {osrq_pkg::KEY_W{pick_v[i]}});
    end
  end

  // control
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    exec_fire  = 1'b0;
    ctl        = '0;
    unique case (state_q)
      osrq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = osrq_pkg::ST_CMP;
        end
      end
      osrq_pkg::ST_CMP: begin
        ctl.cmp_en = 1'b1;
        state_d    = osrq_pkg::ST_EXEC;
      end
      osrq_pkg::ST_EXEC: begin
        ctl.pick_next = (func_q == osrq_pkg::FN_NEXT);
        ctl.pick_prev = (func_q == osrq_pkg::FN_PREV);
        ctl.pick_kth  = (func_q == osrq_pkg::FN_KTH);
        if (!out_valid_q || out_ready_i) begin
          exec_fire  = 1'b1;
          ctl.ins_en = (func_q == osrq_pkg::FN_INSERT) && !present && !full;
          ctl.del_en = (func_q == osrq_pkg::FN_DELETE) && present;
          state_d    = osrq_pkg::ST_IDLE;
        end
      end
      default: state_d = osrq_pkg::ST_IDLE;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= osrq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      key_q  <= key_i;
      rank_q <= rank_i;
    end
  end

  // result
  always_comb begin
    found_d    = 1'b0;
    value_d    = '0;
    overflow_d = 1'b0;
    unique case (func_q)
      osrq_pkg::FN_INSERT: begin
        found_d    = !present && !full;
        overflow_d = !present && full;
      end
      osrq_pkg::FN_DELETE, osrq_pkg::FN_EXISTS: begin
        found_d = present;
      end
      osrq_pkg::FN_NEXT, osrq_pkg::FN_PREV, osrq_pkg::FN_KTH: begin
        found_d = any_pick;
        value_d = pick_val;
      end
      default: begin
        found_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      found_q    <= found_d;
      value_q    <= value_d;
      overflow_q <= overflow_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign value_o     = value_q;
  assign overflow_o  = overflow_q;

  // occupied cells always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_v[CAP-1:1] & ~valid_v[CAP-2:0]) == '0)
    else $error("occupied cells are not contiguous");

  // sorted distinct keys give at most one selected cell
  a_pick_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == osrq_pkg::ST_EXEC |-> $onehot0(pick_v))
    else $error("more than one cell selected");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> out_valid_q && state_q == osrq_pkg::ST_IDLE)
    else $error("executed item has no registered result");

  a_overflow_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(overflow_q && found_q))
    else $error("overflow reported with found");

endmodule
